// ===== rtl/assert_macros.svh =====
// assertion macros used by the responder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/arpc_pkg.sv =====
// types and constants of the arp responder with address cache
package arpc_pkg;

    // default number of cache entries
    localparam int TABLE_DEPTH_DEF = 256;

    // field widths
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int LEN_W    = 8;
    localparam int TYPE_W   = 16;
    localparam int SLOT_W   = 8;
    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 160;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    // protocol constants
    localparam logic [TYPE_W-1:0] HW_ETHERNET    = 16'h0001;
    localparam logic [TYPE_W-1:0] PROTO_IPV4     = 16'h0800;
    localparam logic [TYPE_W-1:0] OPCODE_REQUEST = 16'h0001;

    // item kinds carried in tuser
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MY_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_MAC = 1'b1;

    // cache action codes
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_REFRESH = 2'd1,
        ACT_INSERT  = 2'd2
    } t_action;

    // control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/arp_responder_with_cache_core.sv =====
// arp responder core: ip/mac cache in block memories, linear scan, reply fields
//
//  channel   dir  handshake                     content
//  s_axis    in   tvalid/tready                 arp packet fields or resolve query
//  m_axis    out  tvalid/tready                 reply, cache action and lookup result
//  cfg       in   i_cfg_wr_en (no wait)         my_ip (index 0), my_mac (index 1)
//
// an accepted item is scanned up to the matched slot on a hit or the last filled entry
// on a miss, then finished; there is no scan when the cache is empty or the packet is not
// ethernet/ipv4. the ip memory read port gives one entry per cycle. one item is processed
// at a time, and the next one is accepted in the cycle after the result is loaded.
// reset clears the fill count, insert pointer and control; memories are not cleared,
// entries past the fill count are never used. a stalled result holds in the output
// register while the next item is taken and processed; that item then waits to load it.
`include "assert_macros.svh"

module arp_responder_with_cache_core #(
    parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // hw_type, proto_type, hw_len, proto_len, arp_operation, sender_mac, sender_ip,
    // target_ip, lookup_ip
    input  logic [arpc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // op
    input  logic                                s_axis_tuser,
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // reply_valid, reply_hw_len, reply_proto_len, reply_target_mac, reply_target_ip,
    // cache_action, cache_slot, found, found_mac, zero pad
    output logic [arpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // configuration writes
    input  logic                                i_cfg_wr_en,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);

    // input field views
    logic [arpc_pkg::TYPE_W-1:0] in_hw_type;
    logic [arpc_pkg::TYPE_W-1:0] in_proto_type;
    logic [arpc_pkg::LEN_W-1:0]  in_hw_len;
    logic [arpc_pkg::LEN_W-1:0]  in_proto_len;
    logic [arpc_pkg::TYPE_W-1:0] in_arp_op;
    logic [arpc_pkg::MAC_W-1:0]  in_sender_mac;
    logic [arpc_pkg::IP_W-1:0]   in_sender_ip;
    logic [arpc_pkg::IP_W-1:0]   in_target_ip;
    logic [arpc_pkg::IP_W-1:0]   in_lookup_ip;

    assign in_hw_type    = s_axis_tdata[15:0];
    assign in_proto_type = s_axis_tdata[31:16];
    assign in_hw_len     = s_axis_tdata[39:32];
    assign in_proto_len  = s_axis_tdata[47:40];
    assign in_arp_op     = s_axis_tdata[63:48];
    assign in_sender_mac = s_axis_tdata[111:64];
    assign in_sender_ip  = s_axis_tdata[143:112];
    assign in_target_ip  = s_axis_tdata[175:144];
    assign in_lookup_ip  = s_axis_tdata[207:176];

    // control registers
    arpc_pkg::t_state  r_state, n_state;
    arpc_pkg::t_action r_action, n_action;
    logic [FW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [FW-1:0]     r_scan_cnt, n_scan_cnt;
    logic              r_q_vld, n_q_vld;
    logic              r_hit, n_hit;
    logic              r_m_valid, n_m_valid;
    logic [arpc_pkg::IP_W-1:0] r_my_ip;

    // item payload registers
    logic                          r_op, n_op;
    logic                          r_eth, n_eth;
    logic                          r_tgt_me, n_tgt_me;
    logic                          r_req, n_req;
    logic [arpc_pkg::LEN_W-1:0]    r_hw_len, n_hw_len;
    logic [arpc_pkg::LEN_W-1:0]    r_proto_len, n_proto_len;
    logic [arpc_pkg::MAC_W-1:0]    r_smac, n_smac;
    logic [arpc_pkg::IP_W-1:0]     r_sip, n_sip;
    logic [arpc_pkg::IP_W-1:0]     r_key, n_key;
    logic [AW-1:0]                 r_slot, n_slot;
    logic [arpc_pkg::OUT_DATA_W-1:0] r_m_data, n_m_data;

    // memory ports
    logic [arpc_pkg::IP_W-1:0]  ip_mem  [TABLE_DEPTH];
    logic [arpc_pkg::MAC_W-1:0] mac_mem [TABLE_DEPTH];
    logic [arpc_pkg::IP_W-1:0]  r_ip_q;
    logic [AW-1:0]              r_q_addr;
    logic [arpc_pkg::MAC_W-1:0] r_mac_q;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       ip_we;
    logic                       mac_we;
    logic                       issue;

    // result fields
    logic                       res_reply;
    logic                       res_found;
    logic [arpc_pkg::MAC_W-1:0] res_found_mac;
    logic                       scan_last;

    // views for the checks
    logic                       s_fire;
    logic                       m_found;
    logic [1:0]                 m_action;

    assign rd_addr   = r_scan_cnt[AW-1:0];
    assign wr_addr   = r_hit ? r_slot : r_ptr;
    assign scan_last = (FW'(r_q_addr) + FW'(1)) == r_fill;

    // ip memory: write on insert, scan read
    always_ff @(posedge i_clk) begin
        if (ip_we) begin
            ip_mem[wr_addr] <= r_sip;
        end
        r_ip_q   <= ip_mem[rd_addr];
        r_q_addr <= rd_addr;
    end

    // mac memory: write on refresh or insert, read at the matched slot
    always_ff @(posedge i_clk) begin
        if (mac_we) begin
            mac_mem[wr_addr] <= r_smac;
        end
        r_mac_q <= mac_mem[r_slot];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_ip <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                arpc_pkg::CFG_MY_IP:  r_my_ip <= i_cfg_data[arpc_pkg::IP_W-1:0];
                // reply sender mac is attached downstream, nothing kept here
                arpc_pkg::CFG_MY_MAC: r_my_ip <= r_my_ip;
                default:              r_my_ip <= r_my_ip;
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= arpc_pkg::ST_IDLE;
            r_action   <= arpc_pkg::ACT_NONE;
            r_fill     <= '0;
            r_ptr      <= '0;
            r_scan_cnt <= '0;
            r_q_vld    <= 1'b0;
            r_hit      <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_action   <= n_action;
            r_fill     <= n_fill;
            r_ptr      <= n_ptr;
            r_scan_cnt <= n_scan_cnt;
            r_q_vld    <= n_q_vld;
            r_hit      <= n_hit;
            r_m_valid  <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_eth       <= n_eth;
        r_tgt_me    <= n_tgt_me;
        r_req       <= n_req;
        r_hw_len    <= n_hw_len;
        r_proto_len <= n_proto_len;
        r_smac      <= n_smac;
        r_sip       <= n_sip;
        r_key       <= n_key;
        r_slot      <= n_slot;
        r_m_data    <= n_m_data;
    end

    // result fields from the finished item
    assign res_reply     = (r_op == arpc_pkg::OP_PACKET) && r_eth && r_tgt_me && r_req;
    assign res_found     = (r_op == arpc_pkg::OP_QUERY) && r_hit;
    assign res_found_mac = res_found ? r_mac_q : '0;

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_scan_cnt  = r_scan_cnt;
        n_hit       = r_hit;
        n_op        = r_op;
        n_eth       = r_eth;
        n_tgt_me    = r_tgt_me;
        n_req       = r_req;
        n_hw_len    = r_hw_len;
        n_proto_len = r_proto_len;
        n_smac      = r_smac;
        n_sip       = r_sip;
        n_key       = r_key;
        n_slot      = r_slot;
        n_m_data    = r_m_data;
        issue       = 1'b0;
        ip_we       = 1'b0;
        mac_we      = 1'b0;
        s_axis_tready = (r_state == arpc_pkg::ST_IDLE);
        n_m_valid   = r_m_valid && !m_axis_tready;

        case (r_state)
            // capture a new transaction
            arpc_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op        = s_axis_tuser;
                    n_eth       = (in_hw_type == arpc_pkg::HW_ETHERNET) &&
                                  (in_proto_type == arpc_pkg::PROTO_IPV4);
                    n_tgt_me    = (in_target_ip == r_my_ip);
                    n_req       = (in_arp_op == arpc_pkg::OPCODE_REQUEST);
                    n_hw_len    = in_hw_len;
                    n_proto_len = in_proto_len;
                    n_smac      = in_sender_mac;
                    n_sip       = in_sender_ip;
                    n_key       = (s_axis_tuser == arpc_pkg::OP_QUERY) ? in_lookup_ip
                                                                       : in_sender_ip;
                    n_hit       = 1'b0;
                    n_slot      = '0;
                    n_scan_cnt  = '0;
                    n_action    = arpc_pkg::ACT_NONE;
                    if ((s_axis_tuser == arpc_pkg::OP_PACKET && !n_eth) || r_fill == '0) begin
                        n_state = arpc_pkg::ST_FINISH;
                    end else begin
                        n_state = arpc_pkg::ST_SCAN;
                    end
                end
            end
            // one entry per cycle, stop at the first match or the last written entry
            arpc_pkg::ST_SCAN: begin
                if (r_q_vld && r_ip_q == r_key) begin
                    n_hit   = 1'b1;
                    n_slot  = r_q_addr;
                    n_state = arpc_pkg::ST_FINISH;
                end else if (r_q_vld && scan_last) begin
                    n_state = arpc_pkg::ST_FINISH;
                end else if (r_scan_cnt < r_fill) begin
                    issue      = 1'b1;
                    n_scan_cnt = r_scan_cnt + FW'(1);
                end
            end
            // refresh or insert for a valid packet
            arpc_pkg::ST_FINISH: begin
                if (r_op == arpc_pkg::OP_PACKET && r_eth) begin
                    if (r_hit) begin
                        mac_we   = 1'b1;
                        n_action = arpc_pkg::ACT_REFRESH;
                    end else if (r_tgt_me) begin
                        ip_we    = 1'b1;
                        mac_we   = 1'b1;
                        n_action = arpc_pkg::ACT_INSERT;
                        n_slot   = r_ptr;
                        n_ptr    = (r_ptr == AW'(TABLE_DEPTH - 1)) ? '0 : r_ptr + AW'(1);
                        if (r_fill != FW'(TABLE_DEPTH)) begin
                            n_fill = r_fill + FW'(1);
                        end
                    end
                end
                n_state = arpc_pkg::ST_OUT;
            end
            // load the output register once it is free
            arpc_pkg::ST_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {4'd0,
                                 res_found_mac,
                                 res_found,
                                 arpc_pkg::SLOT_W'(r_slot),
                                 r_action,
                                 res_reply ? r_sip : {arpc_pkg::IP_W{1'b0}},
                                 res_reply ? r_smac : {arpc_pkg::MAC_W{1'b0}},
                                 res_reply ? r_proto_len : {arpc_pkg::LEN_W{1'b0}},
                                 res_reply ? r_hw_len : {arpc_pkg::LEN_W{1'b0}},
                                 res_reply};
                    n_state   = arpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arpc_pkg::ST_IDLE;
            end
        endcase

        n_q_vld = issue;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign m_found  = r_m_valid && r_m_data[107];
    assign m_action = r_m_data[98:97];

    // checks on the control logic
    `ASSERT_IMPLIES(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FW'(TABLE_DEPTH))
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, s_fire, r_state != arpc_pkg::ST_IDLE)
    `ASSERT_IMPLIES(a_read_only_in_scan, i_clk, i_rst_n, r_q_vld, r_state == arpc_pkg::ST_SCAN)
    `ASSERT_IMPLIES(a_found_no_action, i_clk, i_rst_n, m_found, m_action == arpc_pkg::ACT_NONE)

endmodule

// ===== sim/arp_result_monitor.sv =====
// monitor for the arp responder: predicts each result from the input stream and compares
module arp_result_monitor #(
    parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // hw_type, proto_type, hw_len, proto_len, arp_operation, sender_mac, sender_ip,
    // target_ip, lookup_ip
    input  logic [arpc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // op
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // reply_valid, reply_hw_len, reply_proto_len, reply_target_mac, reply_target_ip,
    // cache_action, cache_slot, found, found_mac, zero pad
    input  logic [arpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    // input transaction, first field in the lowest bits
    typedef struct packed {
        logic [arpc_pkg::IP_W-1:0]   lookup_ip;
        logic [arpc_pkg::IP_W-1:0]   target_ip;
        logic [arpc_pkg::IP_W-1:0]   sender_ip;
        logic [arpc_pkg::MAC_W-1:0]  sender_mac;
        logic [arpc_pkg::TYPE_W-1:0] arp_op;
        logic [arpc_pkg::LEN_W-1:0]  proto_len;
        logic [arpc_pkg::LEN_W-1:0]  hw_len;
        logic [arpc_pkg::TYPE_W-1:0] proto_type;
        logic [arpc_pkg::TYPE_W-1:0] hw_type;
    } t_arp_item;

    // result transaction, first field in the lowest bits
    typedef struct packed {
        logic [3:0]                  pad;
        logic [arpc_pkg::MAC_W-1:0]  found_mac;
        logic                        found;
        logic [arpc_pkg::SLOT_W-1:0] cache_slot;
        arpc_pkg::t_action           cache_action;
        logic [arpc_pkg::IP_W-1:0]   reply_target_ip;
        logic [arpc_pkg::MAC_W-1:0]  reply_target_mac;
        logic [arpc_pkg::LEN_W-1:0]  reply_proto_len;
        logic [arpc_pkg::LEN_W-1:0]  reply_hw_len;
        logic                        reply_valid;
    } t_arp_result;

    // shadow of the address cache and the interface address
    logic [arpc_pkg::IP_W-1:0]  ip_tab [TABLE_DEPTH];
    logic [arpc_pkg::MAC_W-1:0] mac_tab [TABLE_DEPTH];
    int                         fill_cnt;
    int                         ins_ptr;
    logic [arpc_pkg::IP_W-1:0]  cur_ip;

    t_arp_result      expected_results [$];
    t_arp_result      got;
    t_arp_result      want;
    int               errs;

    // lowest written slot holding this address, or -1
    function automatic int cache_lookup(input logic [arpc_pkg::IP_W-1:0] ip);
        for (int i = 0; i < fill_cnt; i++) begin
            if (ip_tab[i] == ip) return i;
        end
        return -1;
    endfunction

    // expected result of one transaction, updating the shadow cache
    function automatic t_arp_result resolve_arp(input logic op, input t_arp_item it);
        t_arp_result r;
        int          hit;
        r = '0;
        if (op == arpc_pkg::OP_QUERY) begin
            hit = cache_lookup(it.lookup_ip);
            if (hit >= 0) begin
                r.cache_slot = arpc_pkg::SLOT_W'(hit);
                r.found      = 1'b1;
                r.found_mac  = mac_tab[hit];
            end
            return r;
        end
        // anything but ethernet/ipv4 leaves the cache alone
        if (it.hw_type != arpc_pkg::HW_ETHERNET || it.proto_type != arpc_pkg::PROTO_IPV4)
            return r;
        hit = cache_lookup(it.sender_ip);
        if (hit >= 0) begin
            mac_tab[hit]   = it.sender_mac;
            r.cache_action = arpc_pkg::ACT_REFRESH;
            r.cache_slot   = arpc_pkg::SLOT_W'(hit);
        end
        if (it.target_ip == cur_ip) begin
            // new sender goes into the next free slot, or the oldest once the cache is full
            if (hit < 0) begin
                ip_tab[ins_ptr]  = it.sender_ip;
                mac_tab[ins_ptr] = it.sender_mac;
                r.cache_action   = arpc_pkg::ACT_INSERT;
                r.cache_slot     = arpc_pkg::SLOT_W'(ins_ptr);
                ins_ptr          = (ins_ptr + 1) % TABLE_DEPTH;
                if (fill_cnt < TABLE_DEPTH) fill_cnt++;
            end
            if (it.arp_op == arpc_pkg::OPCODE_REQUEST) begin
                r.reply_valid      = 1'b1;
                r.reply_hw_len     = it.hw_len;
                r.reply_proto_len  = it.proto_len;
                r.reply_target_mac = it.sender_mac;
                r.reply_target_ip  = it.sender_ip;
            end
        end
        return r;
    endfunction

    function automatic int field_bad(input string name, input logic [63:0] exp_v,
                                     input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // watch both channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            fill_cnt = 0;
            ins_ptr  = 0;
            cur_ip   = '0;
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            // result transaction against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_arp_result'(m_axis_tdata);
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none actual %0h",
                             $time, m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    errs = field_bad("reply_valid", 64'(want.reply_valid),
                                     64'(got.reply_valid))
                         + field_bad("reply_hw_len", 64'(want.reply_hw_len),
                                     64'(got.reply_hw_len))
                         + field_bad("reply_proto_len", 64'(want.reply_proto_len),
                                     64'(got.reply_proto_len))
                         + field_bad("reply_target_mac", 64'(want.reply_target_mac),
                                     64'(got.reply_target_mac))
                         + field_bad("reply_target_ip", 64'(want.reply_target_ip),
                                     64'(got.reply_target_ip))
                         + field_bad("cache_action", 64'(want.cache_action),
                                     64'(got.cache_action))
                         + field_bad("cache_slot", 64'(want.cache_slot),
                                     64'(got.cache_slot))
                         + field_bad("found", 64'(want.found), 64'(got.found))
                         + field_bad("found_mac", 64'(want.found_mac),
                                     64'(got.found_mac))
                         + field_bad("pad", 64'(want.pad), 64'(got.pad));
                    o_fail_count <= o_fail_count + errs;
                end
            end
            // register writes
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    arpc_pkg::CFG_MY_IP: begin
                        cur_ip = i_cfg_data[arpc_pkg::IP_W-1:0];
                    end
                    // own mac never shows on the result channel
                    arpc_pkg::CFG_MY_MAC: begin
                    end
                    default: begin
                    end
                endcase
            end
            // input transaction
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(resolve_arp(s_axis_tuser,
                                                       t_arp_item'(s_axis_tdata)));
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// top of the arp responder testbench: clock, reset, stimulus and verdict
module tb;
    import arpc_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // hw_type, proto_type, hw_len, proto_len, arp_operation, sender_mac, sender_ip,
    // target_ip, lookup_ip
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    // op
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // reply_valid, reply_hw_len, reply_proto_len, reply_target_mac, reply_target_ip,
    // cache_action, cache_slot, found, found_mac, zero pad
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    int                     fail_count;
    int                     pending;
    bit                     gaps_on;
    bit                     hold_req;
    logic [IP_W-1:0]        my_ip_now;
    logic [IP_W-1:0]        ip_pool [$];

    arp_responder_with_cache_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    arp_result_monitor mon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // run limit
    initial begin
        #12000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin : rx_drive
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 19);
            end
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom()), $urandom()};
    endfunction

    // offer one transaction and wait until it is taken
    task automatic send(input logic op, input logic [TYPE_W-1:0] hw,
                        input logic [TYPE_W-1:0] pt, input logic [LEN_W-1:0] hl,
                        input logic [LEN_W-1:0] pl, input logic [TYPE_W-1:0] aop,
                        input logic [MAC_W-1:0] smac, input logic [IP_W-1:0] sip,
                        input logic [IP_W-1:0] tip, input logic [IP_W-1:0] lip);
        int gap;
        gap = 0;
        if (gaps_on) begin
            // now and then a long gap so the next item lands at another point
            if ($urandom_range(0, 99) < 3) gap = $urandom_range(1, 300);
            while ($urandom_range(0, 99) < 19) gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {lip, tip, sip, smac, aop, pl, hl, pt, hw};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // set both registers while the block is idle
    task automatic write_cfg(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_MY_IP;
        i_cfg_data  <= CFG_DATA_W'(ip);
        @(posedge i_clk);
        i_cfg_index <= CFG_MY_MAC;
        i_cfg_data  <= mac;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        my_ip_now    = ip;
    endtask

    task automatic remember_ip(input logic [IP_W-1:0] ip);
        ip_pool.push_back(ip);
        if (ip_pool.size() > 96) void'(ip_pool.pop_front());
    endtask

    function automatic logic [IP_W-1:0] pool_or_fresh(input int pct_pool);
        if (ip_pool.size() != 0 && $urandom_range(0, 99) < pct_pool)
            return ip_pool[$urandom_range(0, ip_pool.size() - 1)];
        return $urandom();
    endfunction

    // requests from fresh senders, to push the cache past full
    task automatic fill_burst(input int n);
        logic [IP_W-1:0] sip;
        for (int i = 0; i < n; i++) begin
            sip = $urandom();
            remember_ip(sip);
            send(OP_PACKET, HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, OPCODE_REQUEST,
                 rand_mac(), sip, my_ip_now, $urandom());
        end
    endtask

    // mostly well-formed packets and queries, some noise
    task automatic random_traffic(input int n);
        int              sel;
        logic [TYPE_W-1:0] hw;
        logic [TYPE_W-1:0] pt;
        logic [TYPE_W-1:0] aop;
        logic [IP_W-1:0] sip;
        logic [IP_W-1:0] tip;
        logic [IP_W-1:0] lip;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) == 0) drain();
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                // resolve query, packet fields are noise
                sel = $urandom_range(0, 9);
                if (sel == 0) lip = '0;
                else if (sel == 1) lip = '1;
                else lip = pool_or_fresh(75);
                send(OP_QUERY, 16'($urandom()), 16'($urandom()), 8'($urandom()),
                     8'($urandom()), 16'($urandom()), rand_mac(), $urandom(),
                     $urandom(), lip);
            end else begin
                hw = HW_ETHERNET;
                pt = PROTO_IPV4;
                sel = $urandom_range(0, 99);
                if (sel < 6) hw = 16'($urandom());
                else if (sel < 12) pt = 16'($urandom());
                sel = $urandom_range(0, 99);
                if (sel < 60) aop = OPCODE_REQUEST;
                else if (sel < 85) aop = 16'd2;
                else aop = 16'($urandom());
                sip = pool_or_fresh(40);
                tip = ($urandom_range(0, 99) < 75) ? my_ip_now : $urandom();
                if (tip == my_ip_now) remember_ip(sip);
                send(OP_PACKET, hw, pt, 8'($urandom()), 8'($urandom()), aop, rand_mac(),
                     sip, tip, $urandom());
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [IP_W-1:0] ip_a;
        logic [IP_W-1:0] ip_b;
        logic [IP_W-1:0] ip_c;
        logic [IP_W-1:0] ip_own;
        gaps_on  = 1'b1;
        hold_req = 1'b0;
        ip_a     = 32'h0A00_0001;
        ip_b     = 32'h0A00_0002;
        ip_c     = 32'h0A00_0003;
        ip_own   = 32'hC0A8_0001;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases
        write_cfg(ip_own, 48'h0200_0000_0001);
        // query on an empty cache
        send(OP_QUERY, '0, '0, '0, '0, '0, '0, '0, '0, ip_a);
        // not ethernet, then not ipv4: ignored
        send(OP_PACKET, 16'h0002, PROTO_IPV4, 8'd6, 8'd4, OPCODE_REQUEST,
             48'h1111_1111_1111, ip_a, ip_own, '0);
        send(OP_PACKET, HW_ETHERNET, 16'h86DD, 8'd6, 8'd4, OPCODE_REQUEST,
             48'h1111_1111_1111, ip_a, ip_own, '0);
        // request to us from a new sender: insert and reply
        send(OP_PACKET, HW_ETHERNET, PROTO_IPV4, 8'hFF, 8'h00, OPCODE_REQUEST,
             48'h1111_1111_1111, ip_a, ip_own, '0);
        send(OP_QUERY, '0, '0, '0, '0, '0, '0, '0, '0, ip_a);
        // reply opcode to us: insert without reply
        send(OP_PACKET, HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, 16'd2,
             48'h2222_2222_2222, ip_b, ip_own, '0);
        // cached sender asks us again: refresh and still answer
        send(OP_PACKET, HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, OPCODE_REQUEST,
             48'h3333_3333_3333, ip_a, ip_own, '0);
        send(OP_QUERY, '0, '0, '0, '0, '0, '0, '0, '0, ip_a);
        // cached sender to another target: refresh only
        send(OP_PACKET, HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, OPCODE_REQUEST,
             48'h4444_4444_4444, ip_a, 32'hC0A8_0099, '0);
        // unknown sender to another target: nothing
        send(OP_PACKET, HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, OPCODE_REQUEST,
             48'h5555_5555_5555, ip_c, 32'hC0A8_0099, '0);
        send(OP_QUERY, '0, '0, '0, '0, '0, '0, '0, '0, ip_c);
        // opcodes other than request are never answered
        send(OP_PACKET, HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, 16'd0,
             48'h6666_6666_6666, 32'h0A00_0004, ip_own, '0);
        send(OP_PACKET, HW_ETHERNET, PROTO_IPV4, 8'd6, 8'd4, 16'hFFFF,
             48'h7777_7777_7777, 32'h0A00_0005, ip_own, '0);
        // field extremes
        send(OP_PACKET, HW_ETHERNET, PROTO_IPV4, 8'h00, 8'hFF, OPCODE_REQUEST,
             '1, '1, ip_own, '1);
        send(OP_PACKET, HW_ETHERNET, PROTO_IPV4, 8'hFF, 8'hFF, OPCODE_REQUEST,
             '0, '0, ip_own, '0);
        send(OP_QUERY, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        send(OP_QUERY, '1, '1, '1, '1, '1, '1, '1, '1, '0);
        send(OP_QUERY, '0, '0, '0, '0, '0, '0, '0, '0, ip_b);
        // malformed header with every bit set
        send(OP_PACKET, '1, '1, '1, '1, '1, '1, ip_b, ip_own, '1);
        remember_ip(ip_a);
        remember_ip(ip_b);

        // extreme settings, then random ones
        write_cfg('1, '1);
        random_traffic(220);

        // no idling at all, cache overrun, long receiver hold-off
        gaps_on = 1'b0;
        write_cfg('0, '0);
        fill_burst(140);
        hold_req = 1'b1;
        random_traffic(180);

        gaps_on = 1'b1;
        write_cfg($urandom(), rand_mac());
        random_traffic(220);
        write_cfg($urandom(), rand_mac());
        random_traffic(200);

        drain();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arp_responder_with_cache_core.sv
sim/arp_result_monitor.sv
sim/tb.sv
